FILE: sv/dfr_pkg.sv
// Shared types, constants and defaults for the multichannel packet deframer.
package dfr_pkg;

  localparam int DEF_CHANNELS = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] RST_START_BYTE      = 8'hFF;
  localparam logic [7:0] RST_END_BYTE_FIRST  = 8'h0D;
  localparam logic [7:0] RST_END_BYTE_SECOND = 8'h0A;
  localparam logic [7:0] RST_MAX_LENGTH      = 8'd255;

  typedef enum logic [1:0] {
    CFG_START_BYTE      = 2'd0,
    CFG_END_BYTE_FIRST  = 2'd1,
    CFG_END_BYTE_SECOND = 2'd2,
    CFG_MAX_LENGTH      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_DATA = 2'd1,
    MODE_END  = 2'd2
  } frame_mode_t;

  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_channel;
    logic [7:0] out_byte;
    logic [7:0] byte_position;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte_first;
    logic [7:0] end_byte_second;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    frame_mode_t mode;
    logic [7:0]  pos;
  } chan_state_t;

  localparam chan_state_t RST_CHAN_STATE = '{mode: MODE_HUNT, pos: 8'd0};

endpackage

FILE: sv/dfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dfr_front.sv
// Input side: accepts bytes, drops absent channels and queues the rest.
module dfr_front #(
  parameter int CHANNELS = dfr_pkg::DEF_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfr_pkg::in_item_t in_data,
  output logic              q_valid,
  output dfr_pkg::in_item_t q_item,
  input  logic              q_pop
);
  import dfr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  in_item_t        entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            present;
  logic            push;
  logic            pop;

  assign present  = 32'(in_data.channel) < CHANNELS;
  assign in_ready = count_r != FULL_CNT;
  assign push     = in_valid && in_ready && present;
  assign q_valid  = count_r != '0;
  assign pop      = q_pop && q_valid;
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: sv/dfr_back.sv
// Framing side: per-channel state update, result build and output register.
module dfr_back #(
  parameter int CHANNELS = dfr_pkg::DEF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dfr_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  dfr_pkg::in_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dfr_pkg::out_item_t out_data
);
  import dfr_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $bits(chan_state_t);

  logic              b_valid_r;
  in_item_t          b_item_r;
  logic              byp_r;
  chan_state_t       byp_data_r;
  logic              vld_rd_r;
  logic [CHANNELS-1:0] ent_vld_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              out_free;
  logic              b_fire;
  logic              advance_b;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [SW-1:0]     rdata;
  chan_state_t       st;
  chan_state_t       st_nxt;
  out_item_t         res;
  logic              res_v;

  assign out_free  = !out_valid_r || out_ready;
  assign b_fire    = b_valid_r && out_free;
  assign advance_b = !b_valid_r || out_free;
  assign q_pop     = q_valid && advance_b;
  assign raddr     = AW'(q_item.channel);
  assign waddr     = AW'(b_item_r.channel);

  dfr_ram #(
    .WIDTH (SW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (b_fire),
    .waddr (waddr),
    .wdata (st_nxt),
    .re    (q_pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (byp_r) begin
      st = byp_data_r;
    end else if (vld_rd_r) begin
      st = chan_state_t'(rdata);
    end else begin
      st = RST_CHAN_STATE;
    end
  end

  always_comb begin
    st_nxt = st;
    unique case (st.mode) inside
      MODE_HUNT: begin
        if (b_item_r.rx_byte == cfg.start_byte) begin
          st_nxt.mode = MODE_DATA;
          st_nxt.pos  = 8'd1;
        end
      end
      MODE_DATA, MODE_END: begin
        if (st.pos >= cfg.max_length) begin
          st_nxt = RST_CHAN_STATE;
        end else if (st.mode == MODE_END && b_item_r.rx_byte == cfg.end_byte_second) begin
          st_nxt = RST_CHAN_STATE;
        end else begin
          st_nxt.pos  = st.pos + 8'd1;
          st_nxt.mode = (st.mode == MODE_DATA && b_item_r.rx_byte == cfg.end_byte_first)
                        ? MODE_END : MODE_DATA;
        end
      end
      default: begin
        st_nxt = RST_CHAN_STATE;
      end
    endcase
  end

  always_comb begin
    res                 = '0;
    res.out_channel     = b_item_r.channel;
    res.out_byte        = b_item_r.rx_byte;
    res_v               = 1'b0;
    unique case (st.mode) inside
      MODE_HUNT: begin
        if (b_item_r.rx_byte == cfg.start_byte) begin
          res_v               = 1'b1;
          res.first_of_packet = 1'b1;
        end
      end
      MODE_DATA, MODE_END: begin
        res_v = 1'b1;
        if (st.pos >= cfg.max_length) begin
          res.overflow = 1'b1;
        end else begin
          res.byte_position  = st.pos;
          res.last_of_packet = st.mode == MODE_END
                               && b_item_r.rx_byte == cfg.end_byte_second;
        end
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ent_vld_r   <= '0;
    end else begin
      if (q_pop) begin
        b_valid_r <= 1'b1;
      end else if (advance_b) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire && res_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_fire) begin
        ent_vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item_r   <= q_item;
      byp_r      <= b_fire && (waddr == raddr);
      byp_data_r <= st_nxt;
      vld_rd_r   <= ent_vld_r[raddr];
    end
    if (b_fire && res_v) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/multichannel_packet_deframer.sv
// Top level of the multichannel packet deframer.
// The block takes one received byte per cycle, tagged with its channel, and
// sustains one transaction per clock when the result side is ready; the result
// of a byte passes through the queue and then the state read, after which the
// framing update loads the output register. The per-channel state memory is
// read as a byte leaves the queue, ahead of the update, and written back in the
// update cycle, with a bypass when two bytes of the same channel follow each
// other. Bytes for channels at or above CHANNELS are dropped. Per-channel state
// comes out of reset at once through valid bits, so no clearing pass is needed.
module multichannel_packet_deframer #(
  parameter int CHANNELS = dfr_pkg::DEF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dfr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import dfr_pkg::*;

  cfg_t     cfg_r;
  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= RST_START_BYTE;
      cfg_r.end_byte_first  <= RST_END_BYTE_FIRST;
      cfg_r.end_byte_second <= RST_END_BYTE_SECOND;
      cfg_r.max_length      <= RST_MAX_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START_BYTE:      cfg_r.start_byte      <= cfg_wdata;
        CFG_END_BYTE_FIRST:  cfg_r.end_byte_first  <= cfg_wdata;
        CFG_END_BYTE_SECOND: cfg_r.end_byte_second <= cfg_wdata;
        CFG_MAX_LENGTH:      cfg_r.max_length      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dfr_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  dfr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/dfr_checker.sv
// Port-level checks for the multichannel packet deframer and their binding.
module dfr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dfr_pkg::out_item_t out_data
);
  import dfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed.");

  a_ovf_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.first_of_packet
      && !out_data.last_of_packet && out_data.byte_position == 8'd0)
    else $error("Overflow result carries packet marks or a position.");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.first_of_packet |-> out_data.byte_position == 8'd0
      && !out_data.last_of_packet)
    else $error("Start byte not at position zero.");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_packet |-> out_data.byte_position >= 8'd2)
    else $error("Terminator completed too early in a packet.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind multichannel_packet_deframer dfr_checker u_dfr_checker (.*);
